[src/assert_macros.svh]
// ------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk, off during reset.
// ------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property check
`define RCSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Signal holds in the cycle after cond
`define RCSD_ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

[src/rcsd_pkg.sv]
// ------------------------------------------------------------------
// rcsd_pkg
// Types, widths and register codes of the ray / cylinder unit.
// ------------------------------------------------------------------
package rcsd_pkg;

  // quadric accumulator width (a, k, c)
  localparam int AW  = 100;
  // scaled terms A, K, C
  localparam int AHW = 36;
  localparam int KW  = 37;
  localparam int CW  = 52;
  localparam int FRAC_AK = 60;
  localparam int FRAC_C  = 46;
  // discriminant, its root and the root numerator
  localparam int QW  = 92;
  localparam int RW  = 91;
  localparam int SW  = 44;
  localparam int NW  = 47;
  // divider dividend and quotient
  localparam int XW  = 70;
  localparam int DQW = 32;

  // configuration port
  localparam int CFG_IW = 4;
  localparam logic [CFG_IW-1:0] CFG_CENTER_X = 4'd0;
  localparam logic [CFG_IW-1:0] CFG_CENTER_Y = 4'd1;
  localparam logic [CFG_IW-1:0] CFG_CENTER_Z = 4'd2;
  localparam logic [CFG_IW-1:0] CFG_WEIGHT_X = 4'd3;
  localparam logic [CFG_IW-1:0] CFG_WEIGHT_Y = 4'd4;
  localparam logic [CFG_IW-1:0] CFG_WEIGHT_Z = 4'd5;
  localparam logic [CFG_IW-1:0] CFG_RADIUS   = 4'd6;
  localparam logic [CFG_IW-1:0] CFG_TOL      = 4'd7;

  // reset values
  localparam logic [30:0] WEIGHT_ONE = 31'd1073741824;
  localparam logic [30:0] RADIUS_RST = 31'd65536;
  localparam logic [61:0] RR_RST     = 62'd4294967296;
  localparam logic [30:0] TOL_RST    = 31'd1;

  // input word
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic               on_surface;
  } rcsd_in_t;

  // result word
  typedef struct packed {
    logic        side_positive;
    logic        hit;
    logic [31:0] hit_distance;
  } rcsd_out_t;

  // flags and terms riding along the root pipeline
  typedef struct packed {
    logic                  side;
    logic                  near;
    logic                  cneg;
    logic                  kneg;
    logic                  apos;
    logic                  qneg;
    logic [AHW-1:0]        a_q;
    logic signed [KW-1:0]  k_q;
  } rcsd_sqrt_sb_t;

  // flags and divisor riding along the divider pipeline
  typedef struct packed {
    logic           side;
    logic           hit;
    logic           sat;
    logic [AHW-1:0] a_q;
  } rcsd_div_sb_t;

endpackage

[src/rcsd_isqrt.sv]
// ------------------------------------------------------------------
// rcsd_isqrt
// Pipelined integer square root, one result bit per stage.
// ------------------------------------------------------------------
module rcsd_isqrt import rcsd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [RW-1:0]  in_rem,
  input  rcsd_sqrt_sb_t  in_sb,
  output logic           out_valid,
  output logic [SW-1:0]  out_root,
  output rcsd_sqrt_sb_t  out_sb
);

  logic          v_r    [SW];
  logic [RW-1:0] rem_r  [SW];
  logic [SW-1:0] root_r [SW];
  rcsd_sqrt_sb_t sb_r   [SW];

  for (genvar j = 0; j < SW; j++) begin : g_step
    localparam int B = SW - 1 - j;
    logic          v_in;
    logic [RW-1:0] rem_in;
    logic [SW-1:0] root_in;
    rcsd_sqrt_sb_t sb_in;
    logic [RW-1:0] trial;
    logic          take;
    logic [RW-1:0] rem_nxt;
    logic [SW-1:0] root_nxt;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_rem;
      assign root_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign sb_in   = sb_r[j-1];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial    = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
    assign take     = (rem_in >= trial);
    assign rem_nxt  = take ? (rem_in - trial) : rem_in;
    assign root_nxt = take ? (root_in | (SW'(1) << B)) : root_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        sb_r[j]   <= sb_in;
      end
    end
  end

  assign out_valid = v_r[SW-1];
  assign out_root  = root_r[SW-1];
  assign out_sb    = sb_r[SW-1];

endmodule

[src/rcsd_div.sv]
// ------------------------------------------------------------------
// rcsd_div
// Pipelined restoring divider, one quotient bit per stage.
// ------------------------------------------------------------------
module rcsd_div import rcsd_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [XW-1:0]  in_num,
  input  rcsd_div_sb_t   in_sb,
  output logic           out_valid,
  output logic [DQW-1:0] out_quot,
  output rcsd_div_sb_t   out_sb
);

  logic           v_r    [DQW];
  logic [XW-1:0]  rem_r  [DQW];
  logic [DQW-1:0] quot_r [DQW];
  rcsd_div_sb_t   sb_r   [DQW];

  for (genvar j = 0; j < DQW; j++) begin : g_step
    localparam int B = DQW - 1 - j;
    logic           v_in;
    logic [XW-1:0]  rem_in;
    logic [DQW-1:0] quot_in;
    rcsd_div_sb_t   sb_in;
    logic [XW-1:0]  dsr;
    logic           take;
    logic [XW-1:0]  rem_nxt;
    logic [DQW-1:0] quot_nxt;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign quot_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign quot_in = quot_r[j-1];
      assign sb_in   = sb_r[j-1];
    end

    // divisor aligned to this quotient bit
    assign dsr      = XW'(sb_in.a_q) << B;
    assign take     = (rem_in >= dsr);
    assign rem_nxt  = take ? (rem_in - dsr) : rem_in;
    assign quot_nxt = take ? (quot_in | (DQW'(1) << B)) : quot_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        quot_r[j] <= quot_nxt;
        sb_r[j]   <= sb_in;
      end
    end
  end

  assign out_valid = v_r[DQW-1];
  assign out_quot  = quot_r[DQW-1];
  assign out_sb    = sb_r[DQW-1];

endmodule

[src/ray_cylinder_side_and_distance.sv]
// ------------------------------------------------------------------
// ray_cylinder_side_and_distance
// Side of a cylinder surface and distance along a ray to it.
// ------------------------------------------------------------------
// Takes one ray word per cycle unless stalled and returns one result word
// per ray, in order, through multiply and add stages for the quadric terms
// and the discriminant, a square root (one root bit per stage), root
// selection, a division (one quotient bit per stage) and the output
// register. The whole pipeline holds while a finished word waits under
// out_stall, so in_stall follows out_stall whenever out_valid is high.
// Configuration writes are taken in any cycle (cfg_ready is always high)
// but must only happen while no ray is in flight.
module ray_cylinder_side_and_distance import rcsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rcsd_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rcsd_out_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int KSPLIT = 18;
  localparam int CSPLIT = 26;
  localparam int KKHW   = KW + KW - KSPLIT;
  localparam int KKLW   = KW + KSPLIT + 1;
  localparam int ACHW   = AHW + 1 + CW - CSPLIT;
  localparam int ACLW   = AHW + 1 + CSPLIT + 1;

  // configuration registers
  logic signed [31:0] cen_r [3];
  logic [30:0]        wt_r  [3];
  logic [30:0]        radius_r;
  logic [30:0]        tol_r;
  logic [61:0]        rr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r[0] <= '0;
      cen_r[1] <= '0;
      cen_r[2] <= '0;
      wt_r[0]  <= WEIGHT_ONE;
      wt_r[1]  <= WEIGHT_ONE;
      wt_r[2]  <= '0;
      radius_r <= RADIUS_RST;
      tol_r    <= TOL_RST;
      rr_r     <= RR_RST;
    end else begin
      rr_r <= radius_r * radius_r;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CENTER_X: cen_r[0] <= cfg_data;
          CFG_CENTER_Y: cen_r[1] <= cfg_data;
          CFG_CENTER_Z: cen_r[2] <= cfg_data;
          CFG_WEIGHT_X: wt_r[0]  <= cfg_data[30:0];
          CFG_WEIGHT_Y: wt_r[1]  <= cfg_data[30:0];
          CFG_WEIGHT_Z: wt_r[2]  <= cfg_data[30:0];
          CFG_RADIUS:   radius_r <= cfg_data[30:0];
          CFG_TOL:      tol_r    <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

  // global advance: hold everything while the output word is stalled
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage valid bits
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r, s8_v_r, s9_v_r;
  logic s10_v_r, s11_v_r;

  // stage 1: offsets from the axis point
  logic signed [32:0] s1_dp_r [3];
  logic signed [31:0] s1_du_r [3];
  logic               s1_on_r;
  logic signed [31:0] in_pos [3];
  logic signed [31:0] in_dir [3];

  assign in_pos[0] = in_data.pos_x;
  assign in_pos[1] = in_data.pos_y;
  assign in_pos[2] = in_data.pos_z;
  assign in_dir[0] = in_data.dir_x;
  assign in_dir[1] = in_data.dir_y;
  assign in_dir[2] = in_data.dir_z;

  // stage 2: weighted offset and weighted direction
  logic signed [64:0] s2_wp_r [3];
  logic signed [64:0] s2_wu_r [3];
  logic signed [32:0] s2_dp_r [3];
  logic signed [31:0] s2_du_r [3];
  logic               s2_on_r;

  // stage 3: half-word partial products
  logic signed [65:0] s3_pa_h_r [3];
  logic signed [65:0] s3_pa_l_r [3];
  logic signed [65:0] s3_pk_h_r [3];
  logic signed [65:0] s3_pk_l_r [3];
  logic signed [65:0] s3_pc_h_r [3];
  logic signed [65:0] s3_pc_l_r [3];
  logic               s3_on_r;

  // stage 4: full per-lane terms
  logic signed [AW-1:0] s4_ta_r [3];
  logic signed [AW-1:0] s4_tk_r [3];
  logic signed [AW-1:0] s4_tc_r [3];
  logic                 s4_on_r;

  // stage 5: a, k, c
  logic signed [AW-1:0] s5_a_r, s5_k_r, s5_c_r;
  logic                 s5_on_r;

  // stage 6: side, region flags, scaled terms
  logic signed [AW-1:0] tolb, ntol;
  logic                 side_nxt, near_nxt;
  logic                 s6_side_r, s6_near_r, s6_cneg_r, s6_kneg_r, s6_apos_r;
  logic [AHW-1:0]       s6_a_r;
  logic signed [KW-1:0] s6_k_r;
  logic signed [CW-1:0] s6_c_r;

  // stage 7: discriminant partial products
  logic signed [KKHW-1:0] s7_kk_h_r;
  logic signed [KKLW-1:0] s7_kk_l_r;
  logic signed [ACHW-1:0] s7_ac_h_r;
  logic signed [ACLW-1:0] s7_ac_l_r;
  rcsd_sqrt_sb_t          s7_sb_r;

  // stage 8: K*K and A*C
  logic signed [QW-1:0] s8_kk_r, s8_ac_r;
  rcsd_sqrt_sb_t        s8_sb_r;

  // stage 9: discriminant
  logic signed [QW-1:0] q_nxt;
  logic signed [QW-1:0] s9_q_r;
  rcsd_sqrt_sb_t        s9_sb_nxt;
  rcsd_sqrt_sb_t        s9_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= s7_v_r;
      s9_v_r  <= s8_v_r;
    end
  end

  // lane stages 1 to 4
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_dp_r[i] <= 33'(in_pos[i]) - 33'(cen_r[i]);
        s1_du_r[i] <= in_dir[i];

        s2_wp_r[i] <= $signed({1'b0, wt_r[i]}) * s1_dp_r[i];
        s2_wu_r[i] <= $signed({1'b0, wt_r[i]}) * s1_du_r[i];
        s2_dp_r[i] <= s1_dp_r[i];
        s2_du_r[i] <= s1_du_r[i];

        s3_pa_h_r[i] <= $signed(s2_wu_r[i][64:32]) * s2_du_r[i];
        s3_pa_l_r[i] <= $signed({1'b0, s2_wu_r[i][31:0]}) * s2_du_r[i];
        s3_pk_h_r[i] <= $signed(s2_wp_r[i][64:32]) * s2_du_r[i];
        s3_pk_l_r[i] <= $signed({1'b0, s2_wp_r[i][31:0]}) * s2_du_r[i];
        s3_pc_h_r[i] <= $signed(s2_wp_r[i][64:32]) * s2_dp_r[i];
        s3_pc_l_r[i] <= $signed({1'b0, s2_wp_r[i][31:0]}) * s2_dp_r[i];

        s4_ta_r[i] <= (AW'(s3_pa_h_r[i]) <<< 32) + AW'(s3_pa_l_r[i]);
        s4_tk_r[i] <= (AW'(s3_pk_h_r[i]) <<< 32) + AW'(s3_pk_l_r[i]);
        s4_tc_r[i] <= (AW'(s3_pc_h_r[i]) <<< 32) + AW'(s3_pc_l_r[i]);
      end
      s1_on_r <= in_data.on_surface;
      s2_on_r <= s1_on_r;
      s3_on_r <= s2_on_r;
      s4_on_r <= s3_on_r;
    end
  end

  // side and near-surface tests against the tolerance band
  always_comb begin
    tolb = AW'(tol_r) << FRAC_C;
    ntol = -tolb;
    if (s5_c_r > tolb) begin
      side_nxt = 1'b1;
    end else if (s5_c_r < ntol) begin
      side_nxt = 1'b0;
    end else begin
      side_nxt = !s5_k_r[AW-1] && (s5_k_r != '0);
    end
    near_nxt = s5_on_r || ((s5_c_r > ntol) && (s5_c_r < tolb));
  end

  assign q_nxt = (s8_kk_r <<< 14) - s8_ac_r;

  // flags for the root pipeline, with the discriminant sign
  always_comb begin
    s9_sb_nxt      = s8_sb_r;
    s9_sb_nxt.qneg = q_nxt[QW-1];
  end

  // stages 5 to 9
  always_ff @(posedge clk) begin
    if (en) begin
      s5_a_r  <= s4_ta_r[0] + s4_ta_r[1] + s4_ta_r[2];
      s5_k_r  <= s4_tk_r[0] + s4_tk_r[1] + s4_tk_r[2];
      s5_c_r  <= s4_tc_r[0] + s4_tc_r[1] + s4_tc_r[2] - (AW'(rr_r) << 30);
      s5_on_r <= s4_on_r;

      s6_side_r <= side_nxt;
      s6_near_r <= near_nxt;
      s6_cneg_r <= s5_c_r[AW-1];
      s6_kneg_r <= s5_k_r[AW-1];
      s6_a_r    <= s5_a_r[AHW+FRAC_AK-1:FRAC_AK];
      s6_apos_r <= (s5_a_r[AHW+FRAC_AK-1:FRAC_AK] != '0);
      s6_k_r    <= s5_k_r[KW+FRAC_AK-1:FRAC_AK];
      s6_c_r    <= s5_c_r[CW+FRAC_C-1:FRAC_C];

      s7_kk_h_r <= s6_k_r * $signed(s6_k_r[KW-1:KSPLIT]);
      s7_kk_l_r <= s6_k_r * $signed({1'b0, s6_k_r[KSPLIT-1:0]});
      s7_ac_h_r <= $signed({1'b0, s6_a_r}) * $signed(s6_c_r[CW-1:CSPLIT]);
      s7_ac_l_r <= $signed({1'b0, s6_a_r}) * $signed({1'b0, s6_c_r[CSPLIT-1:0]});
      s7_sb_r.side <= s6_side_r;
      s7_sb_r.near <= s6_near_r;
      s7_sb_r.cneg <= s6_cneg_r;
      s7_sb_r.kneg <= s6_kneg_r;
      s7_sb_r.apos <= s6_apos_r;
      s7_sb_r.qneg <= 1'b0;
      s7_sb_r.a_q  <= s6_a_r;
      s7_sb_r.k_q  <= s6_k_r;

      s8_kk_r <= (QW'(s7_kk_h_r) <<< KSPLIT) + QW'(s7_kk_l_r);
      s8_ac_r <= (QW'(s7_ac_h_r) <<< CSPLIT) + QW'(s7_ac_l_r);
      s8_sb_r <= s7_sb_r;

      s9_q_r  <= q_nxt;
      s9_sb_r <= s9_sb_nxt;
    end
  end

  // square root of the discriminant
  logic           sq_v;
  logic [SW-1:0]  sq_root;
  rcsd_sqrt_sb_t  sq_sb;
  logic [RW-1:0]  sq_rem_in;

  assign sq_rem_in = s9_sb_r.qneg ? '0 : s9_q_r[RW-1:0];

  rcsd_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s9_v_r),
    .in_rem    (sq_rem_in),
    .in_sb     (s9_sb_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_sb    (sq_sb)
  );

  // stage 10: root selection and no-hit cases
  logic                 far_sel, ok_nxt;
  logic signed [NW-1:0] kk7, sroot, n_nxt;
  logic signed [NW-1:0] s10_n_r;
  logic                 s10_side_r, s10_hit_r;
  logic [AHW-1:0]       s10_a_r;

  always_comb begin
    far_sel = sq_sb.near || sq_sb.cneg;
    ok_nxt  = sq_sb.apos && !sq_sb.qneg && !(sq_sb.near && !sq_sb.kneg);
    kk7     = NW'(sq_sb.k_q) <<< 7;
    sroot   = $signed(NW'(sq_root));
    n_nxt   = far_sel ? (sroot - kk7) : (-kk7 - sroot);
  end

  // stage 11: saturation test and dividend
  logic         s11_side_r, s11_hit_r, s11_sat_r;
  logic [AHW-1:0] s11_a_r;
  logic [XW-1:0]  s11_x_r;
  rcsd_div_sb_t   dv_sb_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_v_r <= 1'b0;
      s11_v_r <= 1'b0;
    end else if (en) begin
      s10_v_r <= sq_v;
      s11_v_r <= s10_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_n_r    <= n_nxt;
      s10_hit_r  <= ok_nxt && !n_nxt[NW-1];
      s10_side_r <= sq_sb.side;
      s10_a_r    <= sq_sb.a_q;

      s11_sat_r  <= ({1'b0, s10_n_r[NW-2:0]} >= (NW'(s10_a_r) << 9));
      s11_x_r    <= XW'(s10_n_r[NW-2:0]) << 23;
      s11_hit_r  <= s10_hit_r;
      s11_side_r <= s10_side_r;
      s11_a_r    <= s10_a_r;
    end
  end

  assign dv_sb_in.side = s11_side_r;
  assign dv_sb_in.hit  = s11_hit_r;
  assign dv_sb_in.sat  = s11_sat_r;
  assign dv_sb_in.a_q  = s11_a_r;

  // distance division
  logic           dv_v;
  logic [DQW-1:0] dv_quot;
  rcsd_div_sb_t   dv_sb;

  rcsd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s11_v_r),
    .in_num    (s11_x_r),
    .in_sb     (dv_sb_in),
    .out_valid (dv_v),
    .out_quot  (dv_quot),
    .out_sb    (dv_sb)
  );

  // output register
  logic      out_valid_r;
  rcsd_out_t out_data_r;
  rcsd_out_t out_nxt;

  always_comb begin
    out_nxt.side_positive = dv_sb.side;
    out_nxt.hit           = dv_sb.hit;
    if (!dv_sb.hit) begin
      out_nxt.hit_distance = '0;
    end else if (dv_sb.sat) begin
      out_nxt.hit_distance = '1;
    end else begin
      out_nxt.hit_distance = dv_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/rcsd_checker.sv]
// ------------------------------------------------------------------
// rcsd_checker
// Port-level checks of the ray / cylinder unit, bound to the top level.
// ------------------------------------------------------------------
`include "assert_macros.svh"

module rcsd_checker import rcsd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input rcsd_out_t out_data
);

  // a stalled result word stays offered and unchanged
  `RCSD_ASSERT(a_out_hold, (out_valid && out_stall |=> out_valid), "result word dropped under stall")
  `RCSD_ASSERT_HOLD(a_out_stable, out_valid && out_stall, out_data, "result word changed under stall")

  // a miss always reports zero distance
  `RCSD_ASSERT(a_miss_zero, (out_valid |-> (out_data.hit || out_data.hit_distance == '0)), "miss with nonzero distance")

  // input is held off only by a waiting result word
  `RCSD_ASSERT(a_in_stall, (in_stall |-> (out_valid && out_stall)), "input stalled without output stall")

endmodule

bind ray_cylinder_side_and_distance rcsd_checker u_rcsd_checker (.*);

[tb/sv/testbench.sv]
// ------------------------------------------------------------------
// testbench
// Self-checking bench for the ray / cylinder side and distance unit.
// A clocked driver feeds ray words from a queue that the stimulus
// process fills, a clocked monitor checks every result word against a
// bit-exact predictor. Several register settings are used, each with one
// of four patterns of sender gaps and receiver stalls.
// ------------------------------------------------------------------
module testbench;
  import rcsd_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  rcsd_in_t          in_data;
  logic              out_valid;
  logic              out_stall;
  rcsd_out_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [31:0]       cfg_data;

  ray_cylinder_side_and_distance uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  longint ctr_x, ctr_y, ctr_z, wgt_x, wgt_y, wgt_z, rad, tol;

  rcsd_in_t  ray_q[$];
  rcsd_out_t result_q[$];
  int        errors;
  int        rays_sent;
  int        hits_seen;
  int        cycles;
  int        send_gap_pct;
  int        stall_pct;

  // clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // side and distance of one ray under the current registers
  function automatic rcsd_out_t cyl_eval(rcsd_in_t r);
    logic signed [127:0] a, k, c, tolb, ntol, quad, t1, t2;
    logic [127:0] csq;
    longint dp[3], du[3], wt[3];
    longint wp, wu, A, K, C, N, S;
    longint unsigned un, ua, q, rm;
    logic [63:0] cand, root;
    bit near, ok;
    rcsd_out_t o;
    int i, b;
    dp[0] = longint'(r.pos_x) - ctr_x;
    dp[1] = longint'(r.pos_y) - ctr_y;
    dp[2] = longint'(r.pos_z) - ctr_z;
    du[0] = longint'(r.dir_x);
    du[1] = longint'(r.dir_y);
    du[2] = longint'(r.dir_z);
    wt[0] = wgt_x; wt[1] = wgt_y; wt[2] = wgt_z;
    a = 0; k = 0; c = 0;
    for (i = 0; i < 3; i++) begin
      wp = wt[i] * dp[i];
      wu = wt[i] * du[i];
      t1 = wu; t2 = du[i];
      a = a + t1 * t2;
      t1 = wp;
      k = k + t1 * t2;
      t2 = dp[i];
      c = c + t1 * t2;
    end
    t1 = rad;
    c = c - ((t1 * t1) <<< 30);
    tolb = tol;
    tolb = tolb <<< 46;
    ntol = -tolb;
    o = '0;
    if (c > tolb) o.side_positive = 1'b1;
    else if (c < ntol) o.side_positive = 1'b0;
    else o.side_positive = (k > 0);
    t1 = a >>> 60; A = t1[63:0];
    if (A > 0) begin
      t1 = k >>> 60; K = t1[63:0];
      t1 = c >>> 46; C = t1[63:0];
      t1 = K; t2 = A;
      t1 = (t1 * t1) <<< 14;
      quad = C;
      quad = t1 - t2 * quad;
      if (quad >= 0) begin
        root = 0;
        for (b = 43; b >= 0; b--) begin
          cand = root | (64'd1 << b);
          csq = 128'(cand) * 128'(cand);
          if (csq <= 128'(quad)) root = cand;
        end
        S = root;
        ok = 1;
        near = r.on_surface || (c > ntol && c < tolb);
        if (near) begin
          if (k >= 0) ok = 0;
          N = -K * 128 + S;
        end else if (c < 0) begin
          N = -K * 128 + S;
        end else begin
          N = -K * 128 - S;
        end
        if (ok && N >= 0) begin
          un = N; ua = A;
          q = un / ua; rm = un % ua;
          o.hit = 1'b1;
          if (q >= 512) o.hit_distance = 32'hFFFFFFFF;
          else o.hit_distance = 32'((q << 23) + ((rm << 23) / ua));
        end
      end
    end
    return o;
  endfunction

  // driver: hold a stalled word, otherwise take the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        result_q.push_back(cyl_eval(in_data));
        rays_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (ray_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= ray_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each taken result word against the oldest prediction
  always @(posedge clk) begin
    rcsd_out_t want;
    cycles++;
    if (cycles > 500000) begin
      $display("timeout waiting for results");
      $display("== FAIL ==");
      $finish;
    end
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
      end else begin
        want = result_q.pop_front();
        if (want.hit) hits_seen++;
        if (out_data.side_positive !== want.side_positive) begin
          $error("side_positive: expected %0d got %0d", want.side_positive,
                 out_data.side_positive);
          errors++;
        end
        if (out_data.hit !== want.hit) begin
          $error("hit: expected %0d got %0d", want.hit, out_data.hit);
          errors++;
        end
        if (out_data.hit_distance !== want.hit_distance) begin
          $error("hit_distance: expected %h got %h", want.hit_distance,
                 out_data.hit_distance);
          errors++;
        end
      end
    end
  end

  // one register write, predictor updated once it is taken
  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CENTER_X: ctr_x = longint'($signed(val));
      CFG_CENTER_Y: ctr_y = longint'($signed(val));
      CFG_CENTER_Z: ctr_z = longint'($signed(val));
      CFG_WEIGHT_X: wgt_x = val[30:0];
      CFG_WEIGHT_Y: wgt_y = val[30:0];
      CFG_WEIGHT_Z: wgt_z = val[30:0];
      CFG_RADIUS:   rad   = val[30:0];
      CFG_TOL:      tol   = val[30:0];
      default: ;
    endcase
  endtask

  task automatic set_all(longint cx, longint cy, longint cz, longint wx, longint wy,
                         longint wz, longint r, longint t);
    cfg_write(CFG_CENTER_X, 32'(cx));
    cfg_write(CFG_CENTER_Y, 32'(cy));
    cfg_write(CFG_CENTER_Z, 32'(cz));
    cfg_write(CFG_WEIGHT_X, 32'(wx));
    cfg_write(CFG_WEIGHT_Y, 32'(wy));
    cfg_write(CFG_WEIGHT_Z, 32'(wz));
    cfg_write(CFG_RADIUS,   32'(r));
    cfg_write(CFG_TOL,      32'(t));
  endtask

  task automatic add_ray(longint px, longint py, longint pz, longint ux, longint uy,
                         longint uz, bit on);
    rcsd_in_t r;
    r.pos_x = 32'(px); r.pos_y = 32'(py); r.pos_z = 32'(pz);
    r.dir_x = 32'(ux); r.dir_y = 32'(uy); r.dir_z = 32'(uz);
    r.on_surface = on;
    ray_q.push_back(r);
  endtask

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rnd_dir_comp();
    return longint'($urandom_range(32'h80000000)) - 64'sd1073741824;
  endfunction

  // random ray: mostly aimed near the cylinder with a unit direction
  task automatic add_random_ray();
    real ux, uy, uz, nrm;
    longint span, px, py, pz;
    if ($urandom_range(99) < 20) begin
      add_ray($signed($urandom), $signed($urandom), $signed($urandom),
              rnd_dir_comp(), rnd_dir_comp(), rnd_dir_comp(), $urandom_range(1));
    end else begin
      ux = ($urandom_range(20000) - 10000.0) / 10000.0;
      uy = ($urandom_range(20000) - 10000.0) / 10000.0;
      uz = ($urandom_range(20000) - 10000.0) / 10000.0;
      case ($urandom_range(9))
        0: begin ux = 0.0; uy = 0.0; end
        1: uz = 0.0;
        2: ux = 0.0;
        default: ;
      endcase
      nrm = $sqrt(ux * ux + uy * uy + uz * uz);
      if (nrm < 1.0e-3) begin ux = 0.0; uy = 0.0; uz = 1.0; nrm = 1.0; end
      span = (rad > 64'd65536 ? rad : 64'd65536) * 3;
      if (span > 64'sd1073741824) span = 64'sd1073741824;
      px = clip32(ctr_x + longint'($urandom_range(32'(2 * span))) - span);
      py = clip32(ctr_y + longint'($urandom_range(32'(2 * span))) - span);
      pz = clip32(ctr_z + longint'($urandom_range(32'(2 * span))) - span);
      add_ray(px, py, pz, longint'($rtoi(ux / nrm * 1073741824.0)),
              longint'($rtoi(uy / nrm * 1073741824.0)),
              longint'($rtoi(uz / nrm * 1073741824.0)), ($urandom_range(9) < 2));
    end
  endtask

  // wait until every word is out and the pipe is empty
  task automatic drain();
    while (ray_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic idle_mode(int m);
    case (m % 4)
      0: begin send_gap_pct = 0;  stall_pct = 0;  end
      1: begin send_gap_pct = 62; stall_pct = 0;  end
      2: begin send_gap_pct = 0;  stall_pct = 62; end
      default: begin send_gap_pct = 31; stall_pct = 31; end
    endcase
  endtask

  localparam longint ONE_P = 65536;
  localparam longint ONE_U = 1073741824;

  // stimulus
  initial begin
    longint wx, wy, wz;
    int ph, n, ax;
    errors = 0; rays_sent = 0; hits_seen = 0; cycles = 0;
    send_gap_pct = 0; stall_pct = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    ctr_x = 0; ctr_y = 0; ctr_z = 0;
    wgt_x = ONE_U; wgt_y = ONE_U; wgt_z = 0; rad = ONE_P; tol = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rays on the reset unit cylinder along z
    add_ray(0, 0, 0, ONE_U, 0, 0, 0);                 // inside, far root
    add_ray(-3 * ONE_P, 0, 0, ONE_U, 0, 0, 0);        // outside, near root
    add_ray(-3 * ONE_P, 0, 0, -ONE_U, 0, 0, 0);       // outside, moving away
    add_ray(0, 0, 0, 0, 0, ONE_U, 0);                 // parallel to the axis
    add_ray(-3 * ONE_P, 2 * ONE_P, 0, ONE_U, 0, 0, 0); // misses, no real root
    add_ray(ONE_P, 0, 0, ONE_U, 0, 0, 1);             // on surface, leaving
    add_ray(ONE_P, 0, 0, -ONE_U, 0, 0, 1);            // on surface, entering
    add_ray(ONE_P, 0, 0, -ONE_U, 0, 0, 0);            // within tolerance band
    add_ray(0, 0, 0, 32768, 0, ONE_U - 1, 0);         // tiny slope, saturates
    add_ray(-2 * ONE_P, 0, 0, 32768, 0, ONE_U - 1, 0);
    add_ray(-64'sd2147483648, 0, 0, ONE_U, 0, 0, 0);
    add_ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, -ONE_U, -ONE_U, -ONE_U, 0);
    add_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, ONE_U, ONE_U, ONE_U, 1);
    add_ray(0, 0, 0, -ONE_U, -ONE_U, 0, 0);
    add_ray(0, 0, 0, 0, 0, 0, 0);                     // zero direction
    add_ray(0, 3 * ONE_P, 0, 0, -ONE_U, 0, 0);
    add_ray(0, ONE_P + 1, 0, 0, -ONE_U, 0, 0);
    add_ray(0, ONE_P - 1, 0, 0, ONE_U, 0, 0);
    drain();

    // random phases, each with fresh registers and a new idling pattern
    for (ph = 0; ph < 12; ph++) begin
      idle_mode(ph);
      ax = $urandom_range(2);
      wx = (ax == 0) ? 0 : ONE_U;
      wy = (ax == 1) ? 0 : ONE_U;
      wz = (ax == 2) ? 0 : ONE_U;
      case (ph)
        0: set_all(0, 0, 0, 0, 0, 0, 0, 0);
        1: set_all(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                   ONE_U, ONE_U, ONE_U, 64'd2147483647, 64'd2147483647);
        2: set_all(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
                   wx, wy, wz, 64'd2147483647, 0);
        3: set_all(0, 0, 0, 64'd2147483647, 64'd2147483647, 0, ONE_P, 1);
        4, 5: set_all($signed($urandom), $signed($urandom), $signed($urandom),
                      $urandom_range(ONE_U), $urandom_range(ONE_U),
                      $urandom_range(ONE_U), $urandom_range(32'h7FFFFFFF),
                      $urandom_range(32'h7FFFFFFF));
        default: set_all(longint'($urandom_range(20 * ONE_P)) - 10 * ONE_P,
                         longint'($urandom_range(20 * ONE_P)) - 10 * ONE_P,
                         longint'($urandom_range(20 * ONE_P)) - 10 * ONE_P,
                         wx, wy, wz, $urandom_range(16 * ONE_P),
                         $urandom_range(1 << $urandom_range(20)));
      endcase
      for (n = 0; n < 170; n++) add_random_ray();
      drain();
    end

    $display("%0d rays checked over 13 register settings, %0d of them hits",
             rays_sent, hits_seen);
    $display("sender gaps and receiver stalls varied per setting");
    if (errors == 0 && result_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
